// ===== hw/rtl/alcd_pkg.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// alcd_pkg
// Shared constants and types of the addressable LED chain driver.
// -----------------------------------------------------------------------------
package alcd_pkg;

    localparam int MAX_LEDS  = 64;
    localparam int LED_IDX_W = $clog2(MAX_LEDS);
    localparam int LED_CNT_W = 7;
    localparam int PIX_W     = 24;
    localparam int BIT_CNT_W = 5;

    // op codes carried in tuser
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_LED_COUNT   = 2'd0;
    localparam logic [1:0] CFG_LONG_TICKS  = 2'd1;
    localparam logic [1:0] CFG_SHORT_TICKS = 2'd2;
    localparam logic [1:0] CFG_LATCH_TICKS = 2'd3;

    localparam logic [LED_CNT_W-1:0] RST_LED_COUNT   = LED_CNT_W'(MAX_LEDS);
    localparam logic [7:0]           RST_LONG_TICKS  = 8'd4;
    localparam logic [7:0]           RST_SHORT_TICKS = 8'd1;
    localparam logic [15:0]          RST_LATCH_TICKS = 16'd1140;

    // sequencer to bit shifter
    typedef struct packed {
        logic load;   // take a new pixel, restart at its first bit
        logic shift;  // advance to the next bit
    } sh_ctrl_t;

    // bit shifter to sequencer
    typedef struct packed {
        logic bit_val;   // bit now on the wire
        logic last_bit;  // bit is the last of the LED
    } sh_stat_t;

endpackage : alcd_pkg
`default_nettype wire

// ===== hw/rtl/alcd_pixel_mem.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// alcd_pixel_mem
// Pixel store, one write and one registered read port. Per-entry valid bits
// make never-written entries read as black after reset.
// -----------------------------------------------------------------------------
module alcd_pixel_mem
    import alcd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 wr_en,
    input  wire logic [LED_IDX_W-1:0] wr_addr,
    input  wire logic [PIX_W-1:0]     wr_data,
    input  wire logic [LED_IDX_W-1:0] rd_addr,
    output logic      [PIX_W-1:0]     rd_data
);

    logic [PIX_W-1:0]    pix_mem [MAX_LEDS];
    logic [MAX_LEDS-1:0] vld_reg;
    logic [PIX_W-1:0]    rd_data_reg;
    logic                rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pix_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= pix_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule : alcd_pixel_mem
`default_nettype wire

// ===== hw/rtl/alcd_bit_shifter.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// alcd_bit_shifter
// Holds the LED being sent in GRB order and presents it one bit at a time,
// MSB first.
// -----------------------------------------------------------------------------
module alcd_bit_shifter
    import alcd_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire sh_ctrl_t         ctrl,
    input  wire logic [PIX_W-1:0] rgb,
    output sh_stat_t              stat
);

    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(PIX_W - 1);

    logic [PIX_W-1:0]     sreg_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            // green, red, blue
            sreg_reg <= {rgb[15:8], rgb[23:16], rgb[7:0]};
        end else if (ctrl.shift) begin
            sreg_reg <= {sreg_reg[PIX_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_cnt_reg <= '0;
        end else if (ctrl.load) begin
            bit_cnt_reg <= '0;
        end else if (ctrl.shift) begin
            bit_cnt_reg <= (bit_cnt_reg == LAST_BIT) ? '0 : bit_cnt_reg + 1'b1;
        end
    end

    assign stat.bit_val  = sreg_reg[PIX_W-1];
    assign stat.last_bit = (bit_cnt_reg == LAST_BIT);

endmodule : alcd_bit_shifter
`default_nettype wire

// ===== hw/rtl/addressable_led_chain_driver_unit.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// addressable_led_chain_driver_unit
// Serial LED chain encoder: pixel store, bit shifter and pulse sequencer.
// -----------------------------------------------------------------------------
// Result: registered, on m_tdata/m_tlast in the cycle after the input transfer.
// Throughput: one item per cycle while results are taken; a frame start and
//   every tick that ends an LED while more follow stall the input through ST_FETCH
//   and ST_LOAD while the store's registered read port fetches the next LED.
// Reset: synchronous, active low; registers back to defaults, sender idle,
//   pixel store reads black through per-entry valid bits (no clearing pass).
// -----------------------------------------------------------------------------
module addressable_led_chain_driver_unit
    import alcd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_idx,
    input  wire logic [15:0] cfg_wdata,

    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [5:0] led_index, [29:6] colour, zero pad
    input  wire logic [1:0]  s_tuser,   // [1:0] op

    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [0] data_line, [1] busy_res, [2] status,
                                        // zero pad
    output logic             m_tlast    // frame_done: last tick of the latch gap
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2,
        PH_LATCH = 2'd3
    } phase_t;

    // ST_FETCH: store read in flight; ST_LOAD: read data into the shifter
    typedef enum logic [1:0] {
        ST_RUN,
        ST_FETCH,
        ST_LOAD
    } st_t;

    // configuration
    logic [LED_CNT_W-1:0] led_count_reg;
    logic [7:0]           long_ticks_reg;
    logic [7:0]           short_ticks_reg;
    logic [15:0]          latch_ticks_reg;

    // sequencer
    st_t                  st_reg, st_next;
    phase_t               phase_reg, phase_next;
    logic [15:0]          tick_reg, tick_next;
    logic [LED_CNT_W-1:0] led_cnt_reg, led_cnt_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [7:0]           m_tdata_reg, m_tdata_next;
    logic                 m_tlast_reg, m_tlast_next;

    // input fields
    logic [1:0]           in_op;
    logic [LED_IDX_W-1:0] in_idx;
    logic [PIX_W-1:0]     in_colour;
    logic                 s_xfer;

    // datapath
    sh_ctrl_t             sh_ctrl;
    sh_stat_t             sh_stat;
    logic [PIX_W-1:0]     rd_pix;
    logic                 wr_en;
    logic [15:0]          dur_raw;
    logic [15:0]          dur;
    logic                 phase_end;
    logic [LED_CNT_W-1:0] led_inc;
    logic                 line, busy, status, done;

    assign in_op     = s_tuser;
    assign in_idx    = s_tdata[LED_IDX_W-1:0];
    assign in_colour = s_tdata[LED_IDX_W +: PIX_W];

    // inputs stall while a pixel is fetched or the result slot is full
    assign s_tready = (st_reg == ST_RUN) && (!m_tvalid_reg || m_tready);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // ---------------------------------------------------------------------
    // Configuration registers; led_count is capped at the store depth
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_count_reg   <= RST_LED_COUNT;
            long_ticks_reg  <= RST_LONG_TICKS;
            short_ticks_reg <= RST_SHORT_TICKS;
            latch_ticks_reg <= RST_LATCH_TICKS;
        end else if (cfg_we) begin
            case (cfg_idx)
                CFG_LED_COUNT: begin
                    led_count_reg <= (cfg_wdata[LED_CNT_W-1:0] > LED_CNT_W'(MAX_LEDS))
                                     ? LED_CNT_W'(MAX_LEDS) : cfg_wdata[LED_CNT_W-1:0];
                end
                CFG_LONG_TICKS:  long_ticks_reg  <= cfg_wdata[7:0];
                CFG_SHORT_TICKS: short_ticks_reg <= cfg_wdata[7:0];
                CFG_LATCH_TICKS: latch_ticks_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Pixel store and bit shifter; the store is read at the LED being sent
    // ---------------------------------------------------------------------
    alcd_pixel_mem u_pixel_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (in_idx),
        .wr_data (in_colour),
        .rd_addr (led_cnt_reg[LED_IDX_W-1:0]),
        .rd_data (rd_pix)
    );

    alcd_bit_shifter u_bit_shifter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (sh_ctrl),
        .rgb     (rd_pix),
        .stat    (sh_stat)
    );

    // ---------------------------------------------------------------------
    // Phase length: one bit is long-high/short-low, zero short-high/long-low.
    // A zero length counts as one tick.
    // ---------------------------------------------------------------------
    always_comb begin
        if (phase_reg == PH_LATCH) begin
            dur_raw = latch_ticks_reg;
        end else if (sh_stat.bit_val == (phase_reg == PH_HIGH)) begin
            dur_raw = {8'd0, long_ticks_reg};
        end else begin
            dur_raw = {8'd0, short_ticks_reg};
        end
        dur       = (dur_raw == 16'd0) ? 16'd1 : dur_raw;
        phase_end = ({1'b0, tick_reg} + 17'd1) >= {1'b0, dur};
        led_inc   = led_cnt_reg + LED_CNT_W'(sh_stat.last_bit);
    end

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        st_next       = st_reg;
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        led_cnt_next  = led_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        sh_ctrl       = '0;
        wr_en         = 1'b0;
        line          = 1'b0;
        busy          = 1'b0;
        status        = 1'b0;
        done          = 1'b0;

        case (st_reg)
            ST_RUN: begin
                if (s_xfer) begin
                    m_tvalid_next = 1'b1;
                    case (in_op)
                        OP_TICK: begin
                            if (phase_reg != PH_IDLE) begin
                                busy = 1'b1;
                                line = (phase_reg == PH_HIGH);
                                if (!phase_end) begin
                                    tick_next = tick_reg + 16'd1;
                                end else begin
                                    tick_next = '0;
                                    case (phase_reg)
                                        PH_HIGH: phase_next = PH_LOW;
                                        PH_LOW: begin
                                            sh_ctrl.shift = 1'b1;
                                            led_cnt_next  = led_inc;
                                            if (led_inc >= led_count_reg) begin
                                                phase_next = PH_LATCH;
                                            end else begin
                                                phase_next = PH_HIGH;
                                                // new LED: refill the shifter
                                                if (sh_stat.last_bit) begin
                                                    st_next = ST_FETCH;
                                                end
                                            end
                                        end
                                        default: begin
                                            // end of latch gap
                                            done         = 1'b1;
                                            phase_next   = PH_IDLE;
                                            led_cnt_next = '0;
                                        end
                                    endcase
                                end
                            end
                        end
                        OP_WRITE: begin
                            if (phase_reg != PH_IDLE || {1'b0, in_idx} >= led_count_reg) begin
                                status = 1'b1;
                            end else begin
                                wr_en = 1'b1;
                            end
                        end
                        OP_START: begin
                            if (phase_reg != PH_IDLE) begin
                                status = 1'b1;
                            end else begin
                                led_cnt_next = '0;
                                tick_next    = '0;
                                if (led_count_reg == '0) begin
                                    phase_next = PH_LATCH;
                                end else begin
                                    phase_next = PH_HIGH;
                                    st_next    = ST_FETCH;
                                end
                            end
                        end
                        default: status = 1'b1;
                    endcase
                    // other ops report the line as it stands after them
                    if (in_op != OP_TICK) begin
                        line = (phase_next == PH_HIGH);
                        busy = (phase_next != PH_IDLE);
                    end
                    m_tdata_next = {5'd0, status, busy, line};
                    m_tlast_next = done;
                end
            end
            ST_FETCH: st_next = ST_LOAD;
            ST_LOAD: begin
                sh_ctrl.load = 1'b1;
                st_next      = ST_RUN;
            end
            default: st_next = ST_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_RUN;
            phase_reg    <= PH_IDLE;
            tick_reg     <= '0;
            led_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tlast_reg  <= 1'b0;
        end else begin
            st_reg       <= st_next;
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            led_cnt_reg  <= led_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tlast_reg  <= m_tlast_next;
        end
    end

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // idle sender always points back at the first LED
    a_idle_led0: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> led_cnt_reg == '0)
        else $error("idle with nonzero LED counter");

    // a pixel fetch is only in flight for a bit that is about to go high
    a_fetch_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg != ST_RUN |-> phase_reg == PH_HIGH && tick_reg == '0)
        else $error("pixel fetch outside start of a high phase");

    a_fetch_load: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_FETCH |=> st_reg == ST_LOAD)
        else $error("pixel fetch not followed by shifter load");

    // frame_done only reported on a busy tick with the line low
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[1] && !m_tdata[0])
        else $error("frame_done without busy low line");

endmodule : addressable_led_chain_driver_unit
`default_nettype wire
